@@ hw/rtl/sqt_pkg.sv @@
// shared types, constants and fixed-point helpers of the sarsa q-table update block
`default_nettype none

package sqt_pkg;

  // field widths
  localparam int STATE_W   = 10;
  localparam int ACTION_W  = 4;
  localparam int OUTCOME_W = 3;
  localparam int VALUE_W   = 32;
  localparam int RATE_W    = 17;
  localparam int CFG_IDX_W = 3;

  // datapath widths: difference operand and full product
  localparam int MUL_A_W = 35;
  localparam int PROD_W  = 67;
  localparam int Q_FRAC  = 16;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [PROD_W-1:0]  SAT_HI    = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0]  SAT_LO    = -(PROD_W'(64'sd2147483648));
  localparam logic signed [PROD_W-1:0]  ROUND_HALF = PROD_W'(64'sd32768);

  // register reset values
  localparam logic signed [VALUE_W-1:0] RST_REWARD_SCALE = 32'sd65536;
  localparam logic [RATE_W-1:0]         RST_LEARN_RATE   = 17'd6554;
  localparam logic [RATE_W-1:0]         RST_DISCOUNT     = 17'd58982;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_REWARD   = 3'd0,
    REG_FALL_PENALTY  = 3'd1,
    REG_FAULT_PENALTY = 3'd2,
    REG_GOAL_REWARD   = 3'd3,
    REG_REWARD_SCALE  = 3'd4,
    REG_LEARN_RATE    = 3'd5,
    REG_DISCOUNT      = 3'd6,
    REG_INITIAL_VALUE = 3'd7
  } cfg_reg_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_NORMAL   = 3'd0,
    OC_FALL     = 3'd1,
    OC_FEEDBACK = 3'd2,
    OC_OVERLOAD = 3'd3,
    OC_OVERHEAT = 3'd4,
    OC_TARGET   = 3'd5
  } outcome_t;

  typedef enum logic [3:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ2,
    BK_GAMMA,
    BK_DIFF,
    BK_ALPHA,
    BK_WRITE,
    BK_FILL
  } back_state_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] step_reward;
    logic signed [VALUE_W-1:0] fall_penalty;
    logic signed [VALUE_W-1:0] fault_penalty;
    logic signed [VALUE_W-1:0] goal_reward;
    logic signed [VALUE_W-1:0] reward_scale;
    logic [RATE_W-1:0]         learn_rate;
    logic [RATE_W-1:0]         discount;
    logic signed [VALUE_W-1:0] initial_value;
  } cfg_t;

  // classified transition as it leaves the front end
  typedef struct packed {
    logic                      ends;
    logic                      target;
    logic signed [VALUE_W-1:0] base;
  } item_ctl_t;

  // clamp a wide signed value to 32 bits
  function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [VALUE_W-1:0] res;
    if (v > SAT_HI) begin
      res = VALUE_MAX;
    end else if (v < SAT_LO) begin
      res = VALUE_MIN;
    end else begin
      res = v[VALUE_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sqt_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module sqt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/sqt_cfg.sv @@
// configuration register file
`default_nettype none

module sqt_cfg
  import sqt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  output logic                 ready,
  input  logic [CFG_IDX_W-1:0] index,
  input  logic [VALUE_W-1:0]   data,
  output cfg_t                 cfg
);

  assign ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_reward   <= '0;
      cfg.fall_penalty  <= '0;
      cfg.fault_penalty <= '0;
      cfg.goal_reward   <= '0;
      cfg.reward_scale  <= RST_REWARD_SCALE;
      cfg.learn_rate    <= RST_LEARN_RATE;
      cfg.discount      <= RST_DISCOUNT;
      cfg.initial_value <= '0;
    end else if (valid) begin
      unique case (cfg_reg_t'(index))
        REG_STEP_REWARD:   cfg.step_reward   <= data;
        REG_FALL_PENALTY:  cfg.fall_penalty  <= data;
        REG_FAULT_PENALTY: cfg.fault_penalty <= data;
        REG_GOAL_REWARD:   cfg.goal_reward   <= data;
        REG_REWARD_SCALE:  cfg.reward_scale  <= data;
        REG_LEARN_RATE:    cfg.learn_rate    <= data[RATE_W-1:0];
        REG_DISCOUNT:      cfg.discount      <= data[RATE_W-1:0];
        REG_INITIAL_VALUE: cfg.initial_value <= data;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sqt_front.sv @@
// front end: accepts transitions, reduces indexes, classifies the outcome, forms the base reward
`default_nettype none

module sqt_front
  import sqt_pkg::*;
#(
  parameter int NUM_STATES  = 1024,
  parameter int NUM_ACTIONS = 16,
  localparam int SB = $clog2(NUM_STATES),
  localparam int AB = $clog2(NUM_ACTIONS),
  localparam int AW = $clog2(NUM_STATES * NUM_ACTIONS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 clear_done,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [STATE_W-1:0]   in_cur_state,
  input  logic [ACTION_W-1:0]  in_cur_action,
  input  logic [STATE_W-1:0]   in_succ_state,
  input  logic [ACTION_W-1:0]  in_succ_action,
  input  logic [OUTCOME_W-1:0] in_outcome,
  input  logic                 queue_full,
  output logic                 push,
  output logic [SB-1:0]        push_s1,
  output logic [SB-1:0]        push_s2,
  output logic [AB-1:0]        push_a1,
  output logic [AW-1:0]        push_row_base,
  output logic [AW-1:0]        push_addr1,
  output logic [AW-1:0]        push_addr2,
  output item_ctl_t            push_ctl
);

  // index modulo table size by shifted compare and subtract
  function automatic logic [SB-1:0] reduce_state(input logic [STATE_W-1:0] v);
    logic [31:0] rem;
    rem = 32'(v);
    for (int k = STATE_W - 1; k >= 0; k--) begin
      if (rem >= (32'(NUM_STATES) << k)) begin
        rem = rem - (32'(NUM_STATES) << k);
      end
    end
    return rem[SB-1:0];
  endfunction

  function automatic logic [AB-1:0] reduce_action(input logic [ACTION_W-1:0] v);
    logic [31:0] rem;
    rem = 32'(v);
    for (int k = ACTION_W - 1; k >= 0; k--) begin
      if (rem >= (32'(NUM_ACTIONS) << k)) begin
        rem = rem - (32'(NUM_ACTIONS) << k);
      end
    end
    return rem[AB-1:0];
  endfunction

  logic            stg_valid;
  logic [SB-1:0]   stg_s1;
  logic [SB-1:0]   stg_s2;
  logic [AB-1:0]   stg_a1;
  logic [AB-1:0]   stg_a2;
  item_ctl_t       stg_ctl;
  item_ctl_t       ctl_next;
  logic signed [VALUE_W:0] sum;
  logic            accept;
  logic [AW-1:0]   base2;

  assign in_ready = clear_done && (!stg_valid || !queue_full);
  assign accept   = in_valid && in_ready;
  assign push     = stg_valid && !queue_full;

  // outcome classification and base reward, saturated to 32 bits
  always_comb begin
    ctl_next.ends   = 1'b0;
    ctl_next.target = 1'b0;
    sum = 33'($signed(cfg.step_reward));
    unique case (outcome_t'(in_outcome))
      OC_FALL: begin
        sum = 33'($signed(cfg.step_reward)) + 33'($signed(cfg.fall_penalty));
        ctl_next.ends = 1'b1;
      end
      OC_FEEDBACK, OC_OVERLOAD: begin
        sum = 33'($signed(cfg.step_reward)) + 33'($signed(cfg.fault_penalty));
        ctl_next.ends = 1'b1;
      end
      OC_TARGET: begin
        sum = 33'($signed(cfg.goal_reward));
        ctl_next.ends   = 1'b1;
        ctl_next.target = 1'b1;
      end
      OC_NORMAL, OC_OVERHEAT: begin
        sum = 33'($signed(cfg.step_reward));
      end
      default: begin
        sum = 33'($signed(cfg.step_reward));
      end
    endcase
    if (sum[VALUE_W] != sum[VALUE_W-1]) begin
      ctl_next.base = sum[VALUE_W] ? VALUE_MIN : VALUE_MAX;
    end else begin
      ctl_next.base = sum[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= 1'b1;
    end else if (push) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_s1  <= reduce_state(in_cur_state);
      stg_a1  <= reduce_action(in_cur_action);
      stg_s2  <= reduce_state(in_succ_state);
      stg_a2  <= reduce_action(in_succ_action);
      stg_ctl <= ctl_next;
    end
  end

  // flat table addresses
  assign push_row_base = AW'(32'(stg_s1) * 32'(NUM_ACTIONS));
  assign base2         = AW'(32'(stg_s2) * 32'(NUM_ACTIONS));
  assign push_addr1    = push_row_base + AW'(stg_a1);
  assign push_addr2    = base2 + AW'(stg_a2);
  assign push_s1       = stg_s1;
  assign push_s2       = stg_s2;
  assign push_a1       = stg_a1;
  assign push_ctl      = stg_ctl;

endmodule

`default_nettype wire

@@ hw/rtl/sqt_fifo.sv @@
// small register queue between front and back end
`default_nettype none

module sqt_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sqt_back.sv @@
// back end: table reads, reward scaling, sarsa update, write-back and result register
`default_nettype none

module sqt_back
  import sqt_pkg::*;
#(
  parameter int NUM_STATES  = 1024,
  parameter int NUM_ACTIONS = 16,
  localparam int SB = $clog2(NUM_STATES),
  localparam int AB = $clog2(NUM_ACTIONS),
  localparam int AW = $clog2(NUM_STATES * NUM_ACTIONS)
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  output logic               clear_done,
  input  logic               queue_empty,
  output logic               pop,
  input  logic [SB-1:0]      head_s1,
  input  logic [SB-1:0]      head_s2,
  input  logic [AB-1:0]      head_a1,
  input  logic [AW-1:0]      head_row_base,
  input  logic [AW-1:0]      head_addr1,
  input  logic [AW-1:0]      head_addr2,
  input  item_ctl_t          head_ctl,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [VALUE_W-1:0] res_value,
  output logic [VALUE_W-1:0] res_reward,
  output logic               res_ends,
  output logic               res_target
);

  back_state_t state, state_next;
  logic [SB-1:0] clr_cnt, clr_cnt_next;
  logic [AB-1:0] fill_cnt, fill_cnt_next;

  // working copy of the transition in flight
  logic [SB-1:0] w_s1;
  logic [SB-1:0] w_s2;
  logic [AB-1:0] w_a1;
  logic [AW-1:0] w_row_base;
  logic [AW-1:0] w_addr1;
  logic [AW-1:0] w_addr2;
  item_ctl_t     w_ctl;

  logic signed [VALUE_W-1:0] q;
  logic                      row_ok;
  logic signed [VALUE_W-1:0] r;
  logic signed [MUL_A_W-1:0] diff;
  logic signed [PROD_W-1:0]  prod;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [VALUE_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic                      prod_en;
  logic signed [PROD_W-1:0]  rnd_p;
  logic signed [PROD_W-1:0]  diff_full;
  logic signed [VALUE_W-1:0] entry_val;
  logic signed [VALUE_W-1:0] nv;
  logic                      out_load;

  logic               tbl_we;
  logic [AW-1:0]      tbl_waddr;
  logic [VALUE_W-1:0] tbl_wdata;
  logic [AW-1:0]      tbl_raddr;
  logic [VALUE_W-1:0] tbl_rdata;
  logic               vld_we;
  logic [SB-1:0]      vld_waddr;
  logic [0:0]         vld_wdata;
  logic [SB-1:0]      vld_raddr;
  logic [0:0]         vld_rdata;

  sqt_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (NUM_STATES * NUM_ACTIONS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  sqt_ram #(
    .WIDTH (1),
    .DEPTH (NUM_STATES)
  ) u_row_valid (
    .clk   (clk),
    .we    (vld_we),
    .waddr (vld_waddr),
    .wdata (vld_wdata),
    .raddr (vld_raddr),
    .rdata (vld_rdata)
  );

  assign clear_done = (state != BK_CLEAR);

  // a row never written reads as the initial value
  assign entry_val = vld_rdata[0] ? tbl_rdata : cfg.initial_value;

  assign mul_p     = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign rnd_p     = (prod + ROUND_HALF) >>> Q_FRAC;
  assign nv        = sat32(PROD_W'(q) + rnd_p);
  assign diff_full = w_ctl.ends ? (PROD_W'(r) - PROD_W'(q))
                                : (PROD_W'(r) + rnd_p - PROD_W'(q));

  always_comb begin
    state_next    = state;
    clr_cnt_next  = clr_cnt;
    fill_cnt_next = fill_cnt;
    pop           = 1'b0;
    prod_en       = 1'b0;
    out_load      = 1'b0;
    mul_a         = MUL_A_W'($signed(w_ctl.base));
    mul_b         = cfg.reward_scale;
    tbl_raddr     = w_addr1;
    vld_raddr     = w_s1;
    tbl_we        = 1'b0;
    tbl_waddr     = w_addr1;
    tbl_wdata     = nv;
    vld_we        = 1'b0;
    vld_waddr     = w_s1;
    vld_wdata     = 1'b1;
    unique case (state)
      BK_CLEAR: begin
        vld_we       = 1'b1;
        vld_waddr    = clr_cnt;
        vld_wdata    = 1'b0;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == SB'(NUM_STATES - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        tbl_raddr = head_addr1;
        vld_raddr = head_s1;
        if (!queue_empty) begin
          pop        = 1'b1;
          state_next = BK_READ2;
        end
      end
      BK_READ2: begin
        // second read goes out, base reward times scale
        tbl_raddr  = w_addr2;
        vld_raddr  = w_s2;
        prod_en    = 1'b1;
        state_next = BK_GAMMA;
      end
      BK_GAMMA: begin
        mul_a      = MUL_A_W'(entry_val);
        mul_b      = VALUE_W'(cfg.discount);
        prod_en    = 1'b1;
        state_next = BK_DIFF;
      end
      BK_DIFF: begin
        state_next = BK_ALPHA;
      end
      BK_ALPHA: begin
        mul_a         = diff;
        mul_b         = VALUE_W'(cfg.learn_rate);
        prod_en       = 1'b1;
        fill_cnt_next = '0;
        state_next    = row_ok ? BK_WRITE : BK_FILL;
      end
      BK_WRITE: begin
        tbl_we = 1'b1;
        if (!res_valid || res_ready) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      BK_FILL: begin
        // first touch of a row: whole row gets the initial value, the target entry the update
        tbl_we    = 1'b1;
        tbl_waddr = w_row_base + AW'(fill_cnt);
        tbl_wdata = (fill_cnt == w_a1) ? nv : cfg.initial_value;
        vld_we    = 1'b1;
        if (fill_cnt == AB'(NUM_ACTIONS - 1)) begin
          if (!res_valid || res_ready) begin
            out_load   = 1'b1;
            state_next = BK_IDLE;
          end
        end else begin
          fill_cnt_next = fill_cnt + 1'b1;
        end
      end
      default: begin
        state_next = BK_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_cnt   <= '0;
      fill_cnt  <= '0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_cnt  <= clr_cnt_next;
      fill_cnt <= fill_cnt_next;
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      w_s1       <= head_s1;
      w_s2       <= head_s2;
      w_a1       <= head_a1;
      w_row_base <= head_row_base;
      w_addr1    <= head_addr1;
      w_addr2    <= head_addr2;
      w_ctl      <= head_ctl;
    end
    if (state == BK_READ2) begin
      q      <= entry_val;
      row_ok <= vld_rdata[0];
    end
    if (state == BK_GAMMA) begin
      r <= sat32(rnd_p);
    end
    if (state == BK_DIFF) begin
      diff <= diff_full[MUL_A_W-1:0];
    end
    if (prod_en) begin
      prod <= mul_p;
    end
    if (out_load) begin
      res_value  <= nv;
      res_reward <= r;
      res_ends   <= w_ctl.ends;
      res_target <= w_ctl.target;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sarsa_q_table_update.sv @@
// top level of the sarsa q-table update block
`default_nettype none

// channel  | dir | payload                                        | transaction when
// ---------+-----+------------------------------------------------+------------------------
// s_axis   | in  | tdata: cur_state, cur_action, succ_state,      | s_tvalid && s_tready
//          |     |   succ_action; tuser: outcome                  |
// m_axis   | out | tdata: updated_value, reward_value;            | m_tvalid && m_tready
//          |     |   tlast: episode_end; tuser: reached_target    |
// cfg      | in  | cfg_index, cfg_data                            | cfg_valid && cfg_ready
//
// the back end takes one transition at a time, through the states read2, gamma, diff, alpha and
// write when its state row was written before, or fill on the first touch of a row, which fills
// the whole row; the single shared multiplier and the one read port of the q table set this order
// after reset the row-valid map is swept with s_tready low;
// cfg writes are taken at any time
// the front end holds one transition and the queue two more, so input keeps flowing while a
// result waits in the output register; m_tready low stalls only the back end

module sarsa_q_table_update
  import sqt_pkg::*;
#(
  parameter int NUM_STATES  = 1024,
  parameter int NUM_ACTIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // transition input
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // cur_state[9:0], cur_action[13:10],
                                          // succ_state[23:14], succ_action[27:24], zero
  input  logic [OUTCOME_W-1:0] s_tuser,   // outcome[2:0]
  // update result
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata,   // updated_value[31:0], reward_value[63:32]
  output logic                 m_tlast,   // episode_end
  output logic                 m_tuser,   // reached_target
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_data
);

  localparam int SB         = $clog2(NUM_STATES);
  localparam int AB         = $clog2(NUM_ACTIONS);
  localparam int AW         = $clog2(NUM_STATES * NUM_ACTIONS);
  localparam int QUEUE_DEPTH = 2;
  localparam int ENTRY_W    = 2 * SB + AB + 3 * AW + $bits(item_ctl_t);

  cfg_t cfg;

  // front to queue
  logic          push;
  logic [SB-1:0] f_s1;
  logic [SB-1:0] f_s2;
  logic [AB-1:0] f_a1;
  logic [AW-1:0] f_row_base;
  logic [AW-1:0] f_addr1;
  logic [AW-1:0] f_addr2;
  item_ctl_t     f_ctl;

  // queue to back
  logic          pop;
  logic          queue_full;
  logic          queue_empty;
  logic [SB-1:0] h_s1;
  logic [SB-1:0] h_s2;
  logic [AB-1:0] h_a1;
  logic [AW-1:0] h_row_base;
  logic [AW-1:0] h_addr1;
  logic [AW-1:0] h_addr2;
  item_ctl_t     h_ctl;

  logic [ENTRY_W-1:0] push_word;
  logic [ENTRY_W-1:0] head_word;
  logic               clear_done;
  logic [VALUE_W-1:0] res_value;
  logic [VALUE_W-1:0] res_reward;

  sqt_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .valid (cfg_valid),
    .ready (cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  sqt_front #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .clear_done     (clear_done),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_cur_state   (s_tdata[9:0]),
    .in_cur_action  (s_tdata[13:10]),
    .in_succ_state  (s_tdata[23:14]),
    .in_succ_action (s_tdata[27:24]),
    .in_outcome     (s_tuser),
    .queue_full     (queue_full),
    .push           (push),
    .push_s1        (f_s1),
    .push_s2        (f_s2),
    .push_a1        (f_a1),
    .push_row_base  (f_row_base),
    .push_addr1     (f_addr1),
    .push_addr2     (f_addr2),
    .push_ctl       (f_ctl)
  );

  assign push_word = {f_s1, f_s2, f_a1, f_row_base, f_addr1, f_addr2, f_ctl};
  assign {h_s1, h_s2, h_a1, h_row_base, h_addr1, h_addr2, h_ctl} = head_word;

  sqt_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (push_word),
    .rd_en   (pop),
    .rd_data (head_word),
    .full    (queue_full),
    .empty   (queue_empty)
  );

  sqt_back #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .clear_done    (clear_done),
    .queue_empty   (queue_empty),
    .pop           (pop),
    .head_s1       (h_s1),
    .head_s2       (h_s2),
    .head_a1       (h_a1),
    .head_row_base (h_row_base),
    .head_addr1    (h_addr1),
    .head_addr2    (h_addr2),
    .head_ctl      (h_ctl),
    .res_valid     (m_tvalid),
    .res_ready     (m_tready),
    .res_value     (res_value),
    .res_reward    (res_reward),
    .res_ends      (m_tlast),
    .res_target    (m_tuser)
  );

  assign m_tdata = {res_reward, res_value};

endmodule

`default_nettype wire

@@ sim/tb_sarsa_q_table_update.sv @@
// self-checking testbench for the sarsa q-table update block
`timescale 1ns / 100ps

module tb_sarsa_q_table_update;
  import sqt_pkg::*;

  // outcome codes with no meaning of their own, the block treats them as normal
  localparam logic [OUTCOME_W-1:0] OC_SPARE_SIX   = 3'd6;
  localparam logic [OUTCOME_W-1:0] OC_SPARE_SEVEN = 3'd7;

  localparam int ROWS        = 1024;
  localparam int COLS        = 16;
  localparam int BLOCK_ITEMS = 117;  // transitions between two register reshuffles
  localparam int HOLD_CYCLES = 300;  // long receiver hold-off, fills the input queue

  typedef struct packed {
    logic [STATE_W-1:0]   cur_state;
    logic [ACTION_W-1:0]  cur_action;
    logic [STATE_W-1:0]   succ_state;
    logic [ACTION_W-1:0]  succ_action;
    logic [OUTCOME_W-1:0] outcome;
  } transition_t;

  typedef struct packed {
    logic [VALUE_W-1:0] q_new;
    logic [VALUE_W-1:0] reward;
    logic               ends;
    logic               target;
  } update_t;

  // one row of the directed plan: either a register write or a transition,
  // the latter optionally with its result spelled out by hand
  typedef struct {
    bit                 is_reg;
    cfg_reg_t           reg_idx;
    logic [VALUE_W-1:0] reg_data;
    transition_t        tr;
    bit                 known;
    update_t            want;
  } plan_row_t;

  logic clk;
  logic rst;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;
  logic [OUTCOME_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [63:0]          m_tdata;
  logic                 m_tlast;
  logic                 m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VALUE_W-1:0]   cfg_data = '0;

  // shadow of the block: register copy, q values and the row-valid map
  cfg_t                      cfg_shadow;
  logic signed [VALUE_W-1:0] value_mirror [ROWS*COLS];
  bit                        row_seen [ROWS];

  update_t   pending_updates [$];  // results still owed by the block, oldest first
  plan_row_t directed_plan [$];

  int unsigned mismatch_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_req = 1'b0;

  sarsa_q_table_update #(
    .NUM_STATES (ROWS),
    .NUM_ACTIONS(COLS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // single reset at the start, the block then sweeps its valid map on its own
  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #(20_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // ------------------------------------------------------------------
  // fixed-point helpers of the predictor
  // ------------------------------------------------------------------

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // divide by 2^16, rounding to nearest with ties going up
  function automatic longint round_q16(input longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic longint lookup_q(input logic [STATE_W-1:0] s,
                                      input logic [ACTION_W-1:0] a);
    if (!row_seen[s]) return longint'($signed(cfg_shadow.initial_value));
    return longint'(value_mirror[{s, a}]);
  endfunction

  // sarsa update of the shadow table; both reads happen before the write-back
  function automatic update_t predict_update(input transition_t tr);
    longint  base, rew, q_old, q_next, diff, nv;
    update_t u;
    u.ends = 1'b0;
    u.target = 1'b0;
    base = longint'($signed(cfg_shadow.step_reward));
    case (tr.outcome)
      OC_FALL: begin
        base = base + longint'($signed(cfg_shadow.fall_penalty));
        u.ends = 1'b1;
      end
      OC_FEEDBACK, OC_OVERLOAD: begin
        base = base + longint'($signed(cfg_shadow.fault_penalty));
        u.ends = 1'b1;
      end
      OC_TARGET: begin
        // goal reward replaces the step reward
        base = longint'($signed(cfg_shadow.goal_reward));
        u.ends = 1'b1;
        u.target = 1'b1;
      end
      default: ;  // normal, overheating and the spare codes
    endcase
    base = clamp32(base);
    rew = clamp32(round_q16(base * longint'($signed(cfg_shadow.reward_scale))));
    q_old = lookup_q(tr.cur_state, tr.cur_action);
    q_next = lookup_q(tr.succ_state, tr.succ_action);
    if (u.ends) begin
      diff = rew - q_old;
    end else begin
      diff = rew + round_q16(q_next * longint'(cfg_shadow.discount)) - q_old;
    end
    nv = clamp32(q_old + round_q16(diff * longint'(cfg_shadow.learn_rate)));
    // first touch of a row fills it with the current initial value
    if (!row_seen[tr.cur_state]) begin
      for (int i = 0; i < COLS; i++) begin
        value_mirror[{tr.cur_state, 4'(i)}] = cfg_shadow.initial_value;
      end
      row_seen[tr.cur_state] = 1'b1;
    end
    value_mirror[{tr.cur_state, tr.cur_action}] = VALUE_W'(nv);
    u.q_new = VALUE_W'(nv);
    u.reward = VALUE_W'(rew);
    return u;
  endfunction

  // ------------------------------------------------------------------
  // directed plan
  // ------------------------------------------------------------------

  function automatic transition_t make_tr(input int s, input int a, input int s2,
                                          input int a2, input logic [OUTCOME_W-1:0] oc);
    transition_t tr;
    tr.cur_state = STATE_W'(s);
    tr.cur_action = ACTION_W'(a);
    tr.succ_state = STATE_W'(s2);
    tr.succ_action = ACTION_W'(a2);
    tr.outcome = oc;
    return tr;
  endfunction

  // plan row with every field cleared
  function automatic plan_row_t blank_row();
    plan_row_t row;
    row.is_reg = 1'b0;
    row.reg_idx = REG_STEP_REWARD;
    row.reg_data = '0;
    row.tr = '0;
    row.known = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic void add_row(input plan_row_t row);
    directed_plan.insert(directed_plan.size(), row);
  endfunction

  function automatic void plan_reg(input cfg_reg_t idx, input logic [VALUE_W-1:0] data);
    plan_row_t row;
    row = blank_row();
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_data = data;
    add_row(row);
  endfunction

  function automatic void plan_item(input transition_t tr);
    plan_row_t row;
    row = blank_row();
    row.tr = tr;
    add_row(row);
  endfunction

  function automatic void plan_known(input transition_t tr, input logic [VALUE_W-1:0] qv,
                                     input logic [VALUE_W-1:0] rv, input logic e,
                                     input logic t);
    plan_row_t row;
    row = blank_row();
    row.tr = tr;
    row.known = 1'b1;
    row.want = '{q_new: qv, reward: rv, ends: e, target: t};
    add_row(row);
  endfunction

  function automatic void build_directed_plan();
    // reset settings: all rewards zero and every row at zero, so every result is zero
    plan_known(make_tr(0, 0, 0, 0, OC_NORMAL), 32'h0, 32'h0, 1'b0, 1'b0);
    plan_known(make_tr(1023, 15, 1023, 15, OC_FALL), 32'h0, 32'h0, 1'b1, 1'b0);
    plan_known(make_tr(512, 5, 3, 9, OC_FEEDBACK), 32'h0, 32'h0, 1'b1, 1'b0);
    plan_known(make_tr(3, 9, 512, 5, OC_OVERLOAD), 32'h0, 32'h0, 1'b1, 1'b0);
    plan_known(make_tr(7, 2, 7, 3, OC_OVERHEAT), 32'h0, 32'h0, 1'b0, 1'b0);
    plan_known(make_tr(8, 1, 9, 1, OC_TARGET), 32'h0, 32'h0, 1'b1, 1'b1);
    plan_known(make_tr(9, 14, 8, 1, OC_SPARE_SIX), 32'h0, 32'h0, 1'b0, 1'b0);
    plan_known(make_tr(10, 6, 1023, 0, OC_SPARE_SEVEN), 32'h0, 32'h0, 1'b0, 1'b0);

    // positive saturation of base and scaled reward, alpha of one takes the reward
    plan_reg(REG_STEP_REWARD, 32'h7FFF_FFFF);
    plan_reg(REG_FALL_PENALTY, 32'h7FFF_FFFF);
    plan_reg(REG_REWARD_SCALE, 32'h7FFF_FFFF);
    plan_reg(REG_LEARN_RATE, 32'd65536);
    plan_known(make_tr(100, 3, 7, 2, OC_FALL), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
    // goal reward still zero, so alpha of one drops the entry back to zero
    plan_known(make_tr(100, 3, 0, 0, OC_TARGET), 32'h0, 32'h0, 1'b1, 1'b1);

    // negative saturation through the fault penalty
    plan_reg(REG_STEP_REWARD, 32'h8000_0000);
    plan_reg(REG_FAULT_PENALTY, 32'h8000_0000);
    plan_known(make_tr(101, 0, 5, 5, OC_OVERLOAD), 32'h8000_0000, 32'h8000_0000,
               1'b1, 1'b0);

    // alpha and gamma above one, negative scale, fresh rows at the minimum
    plan_reg(REG_GOAL_REWARD, 32'h7FFF_FFFF);
    plan_reg(REG_REWARD_SCALE, 32'h8000_0000);
    plan_reg(REG_LEARN_RATE, 32'd131071);
    plan_reg(REG_DISCOUNT, 32'd131071);
    plan_reg(REG_INITIAL_VALUE, 32'h8000_0000);
    plan_item(make_tr(200, 8, 201, 8, OC_TARGET));
    plan_item(make_tr(101, 0, 100, 3, OC_NORMAL));
    // same entry read as current and successor
    plan_item(make_tr(101, 0, 101, 0, OC_NORMAL));
    plan_item(make_tr(1023, 15, 0, 0, OC_OVERHEAT));
    plan_item(make_tr(512, 12, 600, 4, OC_SPARE_SIX));
    plan_item(make_tr(600, 4, 512, 12, OC_SPARE_SEVEN));

    // zero alpha and gamma, fresh rows at the maximum
    plan_reg(REG_LEARN_RATE, 32'd0);
    plan_reg(REG_DISCOUNT, 32'd0);
    plan_reg(REG_INITIAL_VALUE, 32'h7FFF_FFFF);
    plan_reg(REG_STEP_REWARD, 32'h0001_0000);
    plan_reg(REG_REWARD_SCALE, 32'h0001_0000);
    plan_item(make_tr(300, 7, 301, 2, OC_NORMAL));
    plan_item(make_tr(301, 2, 300, 7, OC_FALL));
  endfunction

  // ------------------------------------------------------------------
  // random stimulus
  // ------------------------------------------------------------------

  function automatic logic [VALUE_W-1:0] pick_q16();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4: return 32'($urandom);
      default: return 32'($urandom_range(2097152)) - 32'd1048576;  // within +-16.0
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_scale();
    if ($urandom_range(9) < 7) return 32'd65536 + 32'($urandom_range(65536)) - 32'd32768;
    return pick_q16();
  endfunction

  function automatic logic [VALUE_W-1:0] pick_rate();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'd65536;
      2: return 32'd131071;
      3: return 32'($urandom_range(131071));
      default: return 32'($urandom_range(65536));
    endcase
  endfunction

  // mostly a small pool of states so rows are revisited and values build up
  function automatic logic [STATE_W-1:0] pick_state();
    if ($urandom_range(99) < 80) return STATE_W'($urandom_range(15));
    return STATE_W'($urandom);
  endfunction

  function automatic transition_t random_transition();
    transition_t tr;
    tr.cur_state = pick_state();
    tr.cur_action = ACTION_W'($urandom);
    case ($urandom_range(9))
      0: begin
        tr.succ_state = tr.cur_state;
        tr.succ_action = tr.cur_action;
      end
      1, 2: begin
        tr.succ_state = tr.cur_state;
        tr.succ_action = ACTION_W'($urandom);
      end
      default: begin
        tr.succ_state = pick_state();
        tr.succ_action = ACTION_W'($urandom);
      end
    endcase
    tr.outcome = OUTCOME_W'($urandom);
    return tr;
  endfunction

  // ------------------------------------------------------------------
  // driving
  // ------------------------------------------------------------------

  // one register write transaction; the caller lowers cfg_valid after a batch
  task automatic write_reg(input cfg_reg_t idx, input logic [VALUE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_STEP_REWARD:   cfg_shadow.step_reward = data;
      REG_FALL_PENALTY:  cfg_shadow.fall_penalty = data;
      REG_FAULT_PENALTY: cfg_shadow.fault_penalty = data;
      REG_GOAL_REWARD:   cfg_shadow.goal_reward = data;
      REG_REWARD_SCALE:  cfg_shadow.reward_scale = data;
      REG_LEARN_RATE:    cfg_shadow.learn_rate = data[RATE_W-1:0];
      REG_DISCOUNT:      cfg_shadow.discount = data[RATE_W-1:0];
      REG_INITIAL_VALUE: cfg_shadow.initial_value = data;
      default: ;
    endcase
  endtask

  // rewrite a random subset of the registers
  task automatic shuffle_settings();
    cfg_reg_t           idx;
    logic [VALUE_W-1:0] data;
    bit                 wrote;
    wrote = 1'b0;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_reg_t'(i[CFG_IDX_W-1:0]);
      if ($urandom_range(1) == 0) continue;
      case (idx)
        REG_REWARD_SCALE:            data = pick_scale();
        REG_LEARN_RATE, REG_DISCOUNT: data = pick_rate();
        default:                     data = pick_q16();
      endcase
      write_reg(idx, data);
      wrote = 1'b1;
    end
    if (wrote) cfg_valid <= 1'b0;
  endtask

  // offer one transition after a random gap; on acceptance record what it must produce
  task automatic send_transition(input transition_t tr, input bit known,
                                 input update_t want);
    int unsigned gap;
    update_t     pred;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, tr.succ_action, tr.succ_state, tr.cur_action, tr.cur_state};
    s_tuser <= tr.outcome;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // the predictor always runs so that the shadow table follows the block
    pred = predict_update(tr);
    pending_updates.insert(pending_updates.size(), known ? want : pred);
  endtask

  // stop offering and wait until every owed result has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  // checking
  // ------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] want,
                                 input logic [VALUE_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
    end
  endtask

  task automatic check_result();
    update_t want, got;
    got.q_new = m_tdata[31:0];
    got.reward = m_tdata[63:32];
    got.ends = m_tlast;
    got.target = m_tuser;
    if (pending_updates.size() == 0) begin
      report_mismatch("result with nothing pending, updated_value", '0, got.q_new);
      return;
    end
    want = pending_updates.pop_front();
    if (got.q_new !== want.q_new) report_mismatch("updated_value", want.q_new, got.q_new);
    if (got.reward !== want.reward) report_mismatch("reward_value", want.reward, got.reward);
    if (got.ends !== want.ends) report_mismatch("episode_end", 32'(want.ends), 32'(got.ends));
    if (got.target !== want.target) begin
      report_mismatch("reached_target", 32'(want.target), 32'(got.target));
    end
  endtask

  // receiver: checks each result transaction and throttles m_tready
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) check_result();
      // one long hold-off while the sender keeps pushing, the block must back up
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ------------------------------------------------------------------
  // stimulus sequence
  // ------------------------------------------------------------------

  initial begin : stimulus
    bit      reg_phase;
    update_t no_update;
    reg_phase = 1'b0;
    no_update = '0;
    cfg_shadow = '0;
    cfg_shadow.reward_scale = RST_REWARD_SCALE;
    cfg_shadow.learn_rate = RST_LEARN_RATE;
    cfg_shadow.discount = RST_DISCOUNT;
    build_directed_plan();
    tx_idle_pct = 28;
    rx_idle_pct = 48;
    @(posedge clk);
    while (rst) @(posedge clk);

    // directed part; register rows only go in once the block has drained
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_reg) begin
        if (!reg_phase) begin
          wait_drained();
          reg_phase = 1'b1;
        end
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_data);
      end else begin
        if (reg_phase) begin
          cfg_valid <= 1'b0;
          reg_phase = 1'b0;
        end
        send_transition(directed_plan[i].tr, directed_plan[i].known,
                        directed_plan[i].want);
      end
    end

    // random part: three idling regimes, new register settings every block
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 28;
          rx_idle_pct = 48;
        end
        1: begin
          tx_idle_pct = 48;
          rx_idle_pct = 28;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 5; blk++) begin
        wait_drained();
        shuffle_settings();
        if (ph == 2 && blk == 0) hold_req = 1'b1;
        for (int n = 0; n < BLOCK_ITEMS; n++) begin
          send_transition(random_transition(), 1'b0, no_update);
        end
      end
    end

    // let the last results out and give stray ones a chance to show up
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_updates.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
